// ----- hdl/ppts_pkg.sv -----
package ppts_pkg;

  // Default sizing of the task table.
  localparam int NUM_SLOTS_DEF = 8;
  localparam int IDLE_TASK_DEF = 7;

  // A ready task at this priority is never picked.
  localparam logic [7:0] PRIO_NONE = 8'hFF;

  // Operation codes carried by an input beat.
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SCHEDULE    = 3'd1,
    OP_ADD         = 3'd2,
    OP_REMOVE      = 3'd3,
    OP_SUSPEND     = 3'd4,
    OP_RESUME      = 3'd5,
    OP_EXIT        = 3'd6,
    OP_SUSPEND_CUR = 3'd7
  } op_t;

  // Per-slot task state.
  typedef enum logic [1:0] {
    SLOT_DELETED   = 2'd0,
    SLOT_BLOCKED   = 2'd1,
    SLOT_READY     = 2'd2,
    SLOT_SUSPENDED = 2'd3
  } slot_st_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_op;
    logic scan_last;
  } dp_stat_t;

endpackage

// ----- hdl/ppts_ctrl.sv -----
module ppts_ctrl
  import ppts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = stat.scan_op ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/ppts_dpath.sv -----
module ppts_dpath
  import ppts_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int IDLE_TASK = IDLE_TASK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_task_index,
  input  logic        in_any_slot,
  input  logic [31:0] in_period_ticks,
  input  logic [7:0]  in_prio_value,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_out,
  output logic [2:0]  out_running_task,
  output logic [31:0] out_tick_now
);

  localparam int SlotW   = $clog2(NUM_SLOTS);
  localparam int MaxIdx  = (NUM_SLOTS > IDLE_TASK + 1) ? NUM_SLOTS : IDLE_TASK + 1;
  localparam int CurW    = $clog2(MaxIdx);
  localparam int TaskCnt = (IDLE_TASK < NUM_SLOTS) ? IDLE_TASK : NUM_SLOTS;
  localparam int CntW    = $clog2(IDLE_TASK + 1);

  // Task table.
  slot_st_t    st_r   [NUM_SLOTS];
  logic [31:0] per_r  [NUM_SLOTS];
  logic [31:0] rel_r  [NUM_SLOTS];
  logic [7:0]  prio_r [NUM_SLOTS];

  // Captured input beat.
  op_t         op_r;
  logic [3:0]  idx_r;
  logic        any_r;
  logic [31:0] period_in_r;
  logic [7:0]  prio_in_r;

  // Scheduler state and per-item work registers.
  logic [31:0]     tick_r;
  logic [CurW-1:0] cur_r;
  logic [CurW-1:0] scan_idx_r;
  logic [CntW-1:0] scan_cnt_r;
  logic [CurW-1:0] best_r;
  logic [7:0]      best_prio_r;
  logic            found_r;
  logic [CurW-1:0] found_slot_r;
  logic [1:0]      status_r;
  logic [CurW-1:0] slot_o_r;

  logic [SlotW-1:0] rd_addr;
  slot_st_t         rd_st;
  logic [31:0]      rd_per;
  logic [31:0]      rd_rel;
  logic [7:0]       rd_prio;
  logic             idx_in_num;
  logic             idx_task_ok;
  logic             cur_in_num;
  logic             scan_in_num;
  logic             add_direct;
  logic             cur_op;
  logic [CurW:0]    cur_plus;
  logic [CurW-1:0]  sched_start;
  logic [CurW:0]    scan_plus;
  logic [CurW-1:0]  scan_idx_nxt;
  logic [CntW-1:0]  scan_len_m1;

  // Table write ports: one address per field group per cycle.
  logic             st_we;
  logic [SlotW-1:0] st_wa;
  slot_st_t         st_wd;
  logic             rel_we;
  logic [SlotW-1:0] rel_wa;
  logic [31:0]      rel_wd;
  logic             par_we;
  logic [SlotW-1:0] par_wa;

  logic [1:0]      status_nxt;
  logic [CurW-1:0] slot_o_nxt;
  logic [31:0]     cur_ext;
  logic [31:0]     slot_o_ext;

  // Range checks on the addressed slot, the current slot and the scan position.
  assign idx_in_num  = 32'(idx_r) < NUM_SLOTS;
  assign idx_task_ok = idx_in_num && (32'(idx_r) < IDLE_TASK);
  assign cur_in_num  = 32'(cur_r) < NUM_SLOTS;
  assign scan_in_num = 32'(scan_idx_r) < NUM_SLOTS;
  assign cur_op      = (op_r == OP_EXIT) || (op_r == OP_SUSPEND_CUR);

  // Single table read port.
  always_comb begin
    if (cmd.scan_step) begin
      rd_addr = SlotW'(scan_idx_r);
    end else if (cur_op) begin
      rd_addr = SlotW'(cur_r);
    end else begin
      rd_addr = SlotW'(idx_r);
    end
  end

  assign rd_st   = st_r[rd_addr];
  assign rd_per  = per_r[rd_addr];
  assign rd_rel  = rel_r[rd_addr];
  assign rd_prio = prio_r[rd_addr];

  // An add that names a free slot needs no search.
  assign add_direct = (op_r == OP_ADD) && !any_r && idx_in_num && (rd_st == SLOT_DELETED);

  assign stat.scan_op   = (op_r == OP_TICK) || (op_r == OP_SCHEDULE) ||
                          ((op_r == OP_ADD) && !add_direct);
  assign scan_len_m1    = (op_r == OP_SCHEDULE) ? CntW'(IDLE_TASK - 1) : CntW'(TaskCnt - 1);
  assign stat.scan_last = scan_cnt_r == scan_len_m1;

  // Round-robin start after the current slot, and the wrapping scan position.
  assign cur_plus     = {1'b0, cur_r} + (CurW + 1)'(1);
  assign sched_start  = (cur_plus >= (CurW + 1)'(IDLE_TASK)) ? '0 : cur_plus[CurW-1:0];
  assign scan_plus    = {1'b0, scan_idx_r} + (CurW + 1)'(1);
  assign scan_idx_nxt = (scan_plus >= (CurW + 1)'(IDLE_TASK)) ? '0 : scan_plus[CurW-1:0];

  // Table updates and result for the current step.
  always_comb begin
    st_we      = 1'b0;
    st_wa      = rd_addr;
    st_wd      = SLOT_READY;
    rel_we     = 1'b0;
    rel_wa     = rd_addr;
    rel_wd     = tick_r;
    par_we     = 1'b0;
    par_wa     = rd_addr;
    status_nxt = status_r;
    slot_o_nxt = slot_o_r;
    if (cmd.exec) begin
      case (op_r)
        OP_ADD: begin
          if (add_direct) begin
            st_we      = 1'b1;
            rel_we     = 1'b1;
            par_we     = 1'b1;
            slot_o_nxt = CurW'(idx_r);
          end
        end
        OP_REMOVE: begin
          if (idx_task_ok) begin
            st_we = 1'b1;
            st_wd = SLOT_DELETED;
          end else begin
            status_nxt = STAT_BAD;
          end
        end
        OP_SUSPEND: begin
          if (idx_task_ok && (rd_st != SLOT_DELETED)) begin
            st_we = 1'b1;
            st_wd = SLOT_SUSPENDED;
          end else begin
            status_nxt = STAT_BAD;
          end
        end
        OP_RESUME: begin
          if (idx_task_ok && (rd_st == SLOT_SUSPENDED)) begin
            st_we  = 1'b1;
            rel_we = 1'b1;
            rel_wd = tick_r - rd_per;
          end else begin
            status_nxt = STAT_BAD;
          end
        end
        OP_EXIT: begin
          st_we = cur_in_num;
          st_wd = SLOT_BLOCKED;
        end
        OP_SUSPEND_CUR: begin
          st_we = cur_in_num;
          st_wd = SLOT_SUSPENDED;
        end
        default: begin
          st_we = 1'b0;
        end
      endcase
    end else if (cmd.scan_step) begin
      // A tick releases a blocked or ready task whose period has run out.
      if ((op_r == OP_TICK) && scan_in_num &&
          ((rd_st == SLOT_BLOCKED) || (rd_st == SLOT_READY)) &&
          ((tick_r - rd_rel) >= rd_per)) begin
        st_we  = 1'b1;
        rel_we = 1'b1;
      end
    end else if (cmd.commit) begin
      if (op_r == OP_ADD) begin
        st_wa  = SlotW'(found_slot_r);
        rel_wa = SlotW'(found_slot_r);
        par_wa = SlotW'(found_slot_r);
        if (found_r) begin
          st_we      = 1'b1;
          rel_we     = 1'b1;
          par_we     = 1'b1;
          slot_o_nxt = found_slot_r;
        end else begin
          status_nxt = STAT_FULL;
        end
      end else if (op_r == OP_SCHEDULE) begin
        slot_o_nxt = best_r;
      end
    end
  end

  // Task table registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i]   <= SLOT_DELETED;
        per_r[i]  <= '0;
        rel_r[i]  <= '0;
        prio_r[i] <= '0;
      end
    end else begin
      if (st_we) st_r[st_wa] <= st_wd;
      if (rel_we) rel_r[rel_wa] <= rel_wd;
      if (par_we) begin
        per_r[par_wa]  <= period_in_r;
        prio_r[par_wa] <= prio_in_r;
      end
    end
  end

  // Capture of the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(in_operation);
      idx_r       <= in_task_index;
      any_r       <= in_any_slot;
      period_in_r <= in_period_ticks;
      prio_in_r   <= in_prio_value;
    end
  end

  // Tick counter, current task and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      cur_r        <= '0;
      scan_idx_r   <= '0;
      scan_cnt_r   <= '0;
      best_r       <= '0;
      best_prio_r  <= PRIO_NONE;
      found_r      <= 1'b0;
      found_slot_r <= '0;
      status_r     <= STAT_OK;
      slot_o_r     <= '0;
    end else begin
      status_r <= status_nxt;
      slot_o_r <= slot_o_nxt;
      if (cmd.load) begin
        if (in_operation == OP_TICK) tick_r <= tick_r + 32'd1;
        scan_idx_r  <= (in_operation == OP_SCHEDULE) ? sched_start : '0;
        scan_cnt_r  <= '0;
        best_r      <= CurW'(IDLE_TASK);
        best_prio_r <= PRIO_NONE;
        found_r     <= 1'b0;
        status_r    <= STAT_OK;
        slot_o_r    <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_nxt;
        scan_cnt_r <= scan_cnt_r + CntW'(1);
        // Schedule keeps the lowest priority value seen among ready tasks.
        if ((op_r == OP_SCHEDULE) && scan_in_num && (rd_st == SLOT_READY) &&
            (rd_prio < best_prio_r)) begin
          best_prio_r <= rd_prio;
          best_r      <= scan_idx_r;
        end
        // Add remembers the lowest free slot.
        if ((op_r == OP_ADD) && !found_r && (rd_st == SLOT_DELETED)) begin
          found_r      <= 1'b1;
          found_slot_r <= scan_idx_r;
        end
      end
      if (cmd.commit && (op_r == OP_SCHEDULE)) cur_r <= best_r;
    end
  end

  // Result register toward the output channel.
  assign cur_ext    = 32'(cur_r);
  assign slot_o_ext = 32'(slot_o_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= status_r;
      out_slot_out     <= slot_o_ext[2:0];
      out_running_task <= cur_ext[2:0];
      out_tick_now     <= tick_r;
    end
  end

endmodule

// ----- hdl/periodic_priority_task_scheduler.sv -----
// Fixed-priority periodic task scheduler, one operation per input beat.
// Remove, suspend, resume, exit, suspend current and a direct add finish in the execute state;
// tick and a searching add scan min(NUM_SLOTS, IDLE_TASK) slots and schedule scans IDLE_TASK
// slots, each scan followed by a commit state. The table is scanned one slot per cycle.
// A new beat can be taken in the cycle after the result is loaded into the output register.
// Synchronous reset clears the whole task table, tick counter and current task.
module periodic_priority_task_scheduler
  import ppts_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int IDLE_TASK = IDLE_TASK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_task_index,
  input  logic        in_any_slot,
  input  logic [31:0] in_period_ticks,
  input  logic [7:0]  in_prio_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_out,
  output logic [2:0]  out_running_task,
  output logic [31:0] out_tick_now
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  ppts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Task table and scan datapath.
  ppts_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDLE_TASK (IDLE_TASK)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_task_index    (in_task_index),
    .in_any_slot      (in_any_slot),
    .in_period_ticks  (in_period_ticks),
    .in_prio_value    (in_prio_value),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_running_task (out_running_task),
    .out_tick_now     (out_tick_now)
  );

endmodule

// ----- verif/periodic_priority_task_scheduler_chk.sv -----
`timescale 1ns / 100ps

module periodic_priority_task_scheduler_chk
  import ppts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_task_index,
  input  logic        in_any_slot,
  input  logic [31:0] in_period_ticks,
  input  logic [7:0]  in_prio_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [2:0]  out_slot_out,
  input  logic [2:0]  out_running_task,
  input  logic [31:0] out_tick_now,
  output int          error_count,
  output int          results_owed
);

  localparam int NSLOT = NUM_SLOTS_DEF;
  localparam int IDLE  = IDLE_TASK_DEF;

  // One result beat as the block should deliver it.
  typedef struct {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [2:0]  running;
    logic [31:0] tick;
  } sched_result_t;

  // Shadow copy of the task table, tick counter and current task.
  slot_st_t    task_state   [NSLOT];
  logic [31:0] task_period  [NSLOT];
  logic [31:0] task_release [NSLOT];
  logic [7:0]  task_prio    [NSLOT];
  logic [31:0] tick_cnt;
  int          cur_task;

  sched_result_t pending_results[$];

  // Applies one operation to the shadow table and returns the result it yields.
  function automatic sched_result_t apply_beat(logic [2:0] op_bits, logic [3:0] idx,
                                               logic any, logic [31:0] per,
                                               logic [7:0] pri);
    sched_result_t r;
    int            i;
    int            n;
    int            start;
    int            best;
    int            slot;
    logic [7:0]    best_pri;
    logic [31:0]   since;

    r.status = STAT_OK;
    r.slot   = '0;
    case (op_t'(op_bits))
      OP_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        for (i = 0; i < IDLE && i < NSLOT; i++) begin
          since = tick_cnt - task_release[i];
          if ((task_state[i] == SLOT_BLOCKED || task_state[i] == SLOT_READY) &&
              since >= task_period[i]) begin
            task_release[i] = tick_cnt;
            task_state[i]   = SLOT_READY;
          end
        end
      end
      OP_SCHEDULE: begin
        // Round-robin from the slot after the current one; strict less-than keeps
        // the first slot found among equal priorities.
        start = cur_task + 1;
        if (start >= IDLE) start = 0;
        best     = IDLE;
        best_pri = PRIO_NONE;
        for (n = 0; n < IDLE; n++) begin
          i = start + n;
          if (i >= IDLE) i = i - IDLE;
          if (i < NSLOT && task_state[i] == SLOT_READY && task_prio[i] < best_pri) begin
            best_pri = task_prio[i];
            best     = i;
          end
        end
        cur_task = best;
        r.slot   = best[2:0];
      end
      OP_ADD: begin
        slot = NSLOT;
        if (!any && idx < NSLOT && task_state[idx] == SLOT_DELETED) slot = idx;
        for (i = 0; i < IDLE && i < NSLOT; i++) begin
          if (slot >= NSLOT && task_state[i] == SLOT_DELETED) slot = i;
        end
        if (slot >= NSLOT) begin
          r.status = STAT_FULL;
        end else begin
          task_period[slot]  = per;
          task_release[slot] = tick_cnt;
          task_prio[slot]    = pri;
          task_state[slot]   = SLOT_READY;
          r.slot             = slot[2:0];
        end
      end
      OP_REMOVE: begin
        if (idx >= IDLE) r.status = STAT_BAD;
        else task_state[idx] = SLOT_DELETED;
      end
      OP_SUSPEND: begin
        if (idx >= IDLE || task_state[idx] == SLOT_DELETED) r.status = STAT_BAD;
        else task_state[idx] = SLOT_SUSPENDED;
      end
      OP_RESUME: begin
        if (idx >= IDLE || task_state[idx] != SLOT_SUSPENDED) begin
          r.status = STAT_BAD;
        end else begin
          task_state[idx]   = SLOT_READY;
          task_release[idx] = tick_cnt - task_period[idx];
        end
      end
      OP_EXIT: begin
        if (cur_task < NSLOT) task_state[cur_task] = SLOT_BLOCKED;
      end
      default: begin
        if (cur_task < NSLOT) task_state[cur_task] = SLOT_SUSPENDED;
      end
    endcase
    r.running = cur_task[2:0];
    r.tick    = tick_cnt;
    return r;
  endfunction

  // Compare each result beat with the oldest prediction, then predict from the input beat.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        task_state[i]   = SLOT_DELETED;
        task_period[i]  = '0;
        task_release[i] = '0;
        task_prio[i]    = '0;
      end
      tick_cnt = '0;
      cur_task = 0;
      pending_results.delete();
      error_count  = 0;
      results_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no beat outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            error_count++;
          end
          if (out_running_task !== want.running) begin
            $error("running_task: expected %0d, got %0d", want.running, out_running_task);
            error_count++;
          end
          if (out_tick_now !== want.tick) begin
            $error("tick_now: expected %0d, got %0d", want.tick, out_tick_now);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_beat(in_operation, in_task_index, in_any_slot,
                                             in_period_ticks, in_prio_value));
      end
      results_owed = pending_results.size();
    end
  end

endmodule

// ----- verif/periodic_priority_task_scheduler_tb.sv -----
`timescale 1ns / 100ps

module periodic_priority_task_scheduler_tb;
  import ppts_pkg::*;

  localparam int RANDOM_BEATS = 650;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [3:0]  in_task_index;
  logic        in_any_slot;
  logic [31:0] in_period_ticks;
  logic [7:0]  in_prio_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [2:0]  out_slot_out;
  logic [2:0]  out_running_task;
  logic [31:0] out_tick_now;
  int          fail_count;
  int          results_owed;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  periodic_priority_task_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_task_index    (in_task_index),
    .in_any_slot      (in_any_slot),
    .in_period_ticks  (in_period_ticks),
    .in_prio_value    (in_prio_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_running_task (out_running_task),
    .out_tick_now     (out_tick_now)
  );

  periodic_priority_task_scheduler_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_task_index    (in_task_index),
    .in_any_slot      (in_any_slot),
    .in_period_ticks  (in_period_ticks),
    .in_prio_value    (in_prio_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_running_task (out_running_task),
    .out_tick_now     (out_tick_now),
    .error_count      (fail_count),
    .results_owed     (results_owed)
  );

  // Presents one beat at the falling edge and holds it until the block takes it.
  task automatic offer_beat(op_t op, logic [3:0] idx, logic any, logic [31:0] per,
                            logic [7:0] pri);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_task_index   <= idx;
    in_any_slot     <= any;
    in_period_ticks <= per;
    in_prio_value   <= pri;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid for the given number of cycles (at least one).
  task automatic go_quiet(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds off the input until every predicted result has been delivered.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Random beat: ticks and schedules most often, over a churning table, with small
  // periods and a narrow priority range so ties and releases happen often.
  task automatic offer_random_beat();
    op_t         op;
    logic [3:0]  idx;
    logic [31:0] per;
    logic [7:0]  pri;
    int          pick;

    pick = $urandom_range(0, 99);
    if (pick < 28)      op = OP_TICK;
    else if (pick < 48) op = OP_SCHEDULE;
    else if (pick < 64) op = OP_ADD;
    else if (pick < 72) op = OP_REMOVE;
    else if (pick < 80) op = OP_SUSPEND;
    else if (pick < 88) op = OP_RESUME;
    else if (pick < 94) op = OP_EXIT;
    else                op = OP_SUSPEND_CUR;

    idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));

    pick = $urandom_range(0, 9);
    if (pick < 6)       per = $urandom_range(0, 4);
    else if (pick < 8)  per = $urandom_range(5, 30);
    else if (pick == 8) per = $urandom();
    else                per = 32'hFFFF_FFFF - $urandom_range(0, 3);

    pick = $urandom_range(0, 9);
    if (pick < 4)       pri = 8'($urandom_range(0, 3));
    else if (pick < 8)  pri = 8'($urandom());
    else if (pick == 8) pri = PRIO_NONE;
    else                pri = 8'($urandom_range(250, 254));

    offer_beat(op, idx, 1'($urandom_range(0, 1)), per, pri);
  endtask

  // Sender: reset, directed beats, then random bursts.
  initial begin
    int k;
    int burst_left;
    int gap;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_TICK;
    in_task_index   = '0;
    in_any_slot     = 1'b0;
    in_period_ticks = '0;
    in_prio_value   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Nothing is ready yet, so schedule falls back to the idle slot.
    offer_beat(OP_SCHEDULE, 4'd5, 1'b1, 32'h0, 8'h00);
    // A direct add is the only way to fill the idle slot.
    offer_beat(OP_ADD, 4'd7, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_ADD, 4'd3, 1'b0, 32'hFFFF_FFFF, PRIO_NONE);
    // Requested slot taken, and an index past the table: both search for a free slot.
    offer_beat(OP_ADD, 4'd3, 1'b0, 32'd2, 8'd5);
    offer_beat(OP_ADD, 4'd15, 1'b1, 32'h0, 8'h80);
    offer_beat(OP_ADD, 4'd12, 1'b0, 32'd1, 8'd5);
    offer_beat(OP_TICK, 4'd0, 1'b0, 32'h5555_5555, 8'hAA);
    offer_beat(OP_TICK, 4'd0, 1'b1, 32'hAAAA_AAAA, 8'h55);
    offer_beat(OP_SCHEDULE, 4'd0, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_EXIT, 4'd15, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    offer_beat(OP_SCHEDULE, 4'd0, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_SUSPEND_CUR, 4'd0, 1'b0, 32'h0, 8'h00);
    // Rejected requests: deleted slot, index past the table, task not suspended.
    offer_beat(OP_SUSPEND, 4'd4, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_SUSPEND, 4'd9, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_RESUME, 4'd1, 1'b0, 32'h0, 8'h00);
    // Resume backdates the last release by the full period, which wraps here.
    offer_beat(OP_SUSPEND, 4'd3, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_RESUME, 4'd3, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_TICK, 4'd0, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_REMOVE, 4'd7, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_REMOVE, 4'd15, 1'b0, 32'h0, 8'h00);
    // Fill every slot that a search covers, then one more add finds no free slot.
    offer_beat(OP_ADD, 4'd0, 1'b1, 32'd3, 8'd1);
    offer_beat(OP_ADD, 4'd0, 1'b1, 32'd0, 8'd1);
    offer_beat(OP_ADD, 4'd0, 1'b1, 32'd1, 8'd254);
    offer_beat(OP_ADD, 4'd6, 1'b0, 32'd0, 8'd0);
    offer_beat(OP_SCHEDULE, 4'd0, 1'b0, 32'h0, 8'h00);
    offer_beat(OP_REMOVE, 4'd0, 1'b0, 32'h0, 8'h00);
    wait_all_results();

    burst_left = 0;
    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k == RANDOM_BEATS / 2) wait_all_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) go_quiet(gap);
      end
      offer_random_beat();
      burst_left--;
    end

    wait_all_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("periodic_priority_task_scheduler_tb: done, clean");
    end else begin
      $display("periodic_priority_task_scheduler_tb: done, errors");
    end
    $finish;
  end

  // Receiver: one long hold-off early on while the sender keeps offering, then a
  // mix of free-flowing stretches, random stalls and further long holds.
  initial begin
    int mode;
    int len;

    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    repeat (40) @(negedge clk);
    out_stall <= 1'b1;
    repeat (80) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        len = $urandom_range(5, 40);
        repeat (len) begin
          out_stall <= 1'b0;
          @(negedge clk);
        end
      end else if (mode < 9) begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(negedge clk);
        end
      end else begin
        len = $urandom_range(40, 90);
        repeat (len) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #5ms;
    $display("periodic_priority_task_scheduler_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ppts_pkg.sv
hdl/ppts_ctrl.sv
hdl/ppts_dpath.sv
hdl/periodic_priority_task_scheduler.sv
verif/periodic_priority_task_scheduler_chk.sv
verif/periodic_priority_task_scheduler_tb.sv
